[design/jet_angularity_accumulator_unit_defines.svh]
// ---------------------------------------------------------------------------
// Jet angularity accumulator: assertion macros
// Shared property shorthands for the RTL assertions.
// ---------------------------------------------------------------------------
`ifndef JET_ANGULARITY_ACCUMULATOR_UNIT_DEFINES_SVH
`define JET_ANGULARITY_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define JAA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define JAA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/jaa_pkg.sv]
// ---------------------------------------------------------------------------
// jaa_pkg
// Types and fixed constants of the jet angularity accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package jaa_pkg;

   // input word
   typedef struct packed {
      logic [15:0] particle_pt;
      logic [12:0] distance_to_axis;
      logic [12:0] jet_abs_rapidity;
      logic        last_particle;
   } req_type;

   // result word
   typedef struct packed {
      logic [8:0]  multiplicity;
      logic [16:0] angularity_pt2;
      logic [16:0] angularity_pt1;
      logic [16:0] angularity_pt_half;
      logic [16:0] angularity_dist2;
      logic [2:0]  rapidity_bin;
      logic        rapidity_valid;
      logic        degenerate;
   } rsp_type;

   // shift/subtract unit widths; sized for up to 1024 constituents
   localparam int NUM_W      = 64;
   localparam int DEN_W      = 60;
   localparam int Q_W        = 19;
   localparam int DSH_W      = DEN_W + Q_W - 1;
   localparam int SQ_W       = 34;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int SQ_REM_W   = ROOT_W + 1;
   localparam int STEP_W     = 5;
   localparam int SQ_STEPS   = ROOT_W;
   localparam int DIV_STEPS  = Q_W;
   localparam int MUL_W      = 32;

   localparam logic [16:0] SAT_ONE   = 17'd65536;
   localparam logic [12:0] RAP_TOP   = 13'd4700;
   localparam logic [DEN_W-1:0] DIST2_DEN = DEN_W'(25600);

   localparam logic [12:0] RAP_EDGE [0:7] = '{13'd0, 13'd500, 13'd1000, 13'd1500,
                                              13'd2000, 13'd2500, 13'd3000, 13'd4700};

   typedef enum logic [0:0] {
      SU_SQRT = 1'b0,
      SU_DIV  = 1'b1
   } su_mode_type;

   typedef struct packed {
      logic        start;
      su_mode_type mode;
   } su_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } su_sts_type;

   // largest edge index (1..6) not above rap, else 0
   function automatic logic [2:0] rap_bin_f(input logic [12:0] rap);
      logic [2:0] bin;
      bin = '0;
      for (int k = 1; k < 7; k++) begin
         if (rap >= RAP_EDGE[k]) bin = 3'(k);
      end
      return bin;
   endfunction

endpackage

`default_nettype wire

[design/jaa_mul.sv]
// ---------------------------------------------------------------------------
// jaa_mul
// Shared 32x32 multiplier with registered product, loaded on enable.
// ---------------------------------------------------------------------------
`default_nettype none

module jaa_mul (
   input  wire logic                       clock,
   input  wire logic                       issue,
   input  wire logic [jaa_pkg::MUL_W-1:0]  a,
   input  wire logic [jaa_pkg::MUL_W-1:0]  b,
   output      logic [2*jaa_pkg::MUL_W-1:0] prod
);
   import jaa_pkg::*;

   logic [2*MUL_W-1:0] prod_ff;

   // product holds until the next issue
   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

[design/jaa_shift_sub.sv]
// ---------------------------------------------------------------------------
// jaa_shift_sub
// Shared shift/subtract unit: integer square root (two bits a step) or
// restoring division (one quotient bit a step).
// ---------------------------------------------------------------------------
`default_nettype none

`include "jet_angularity_accumulator_unit_defines.svh"

module jaa_shift_sub (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire jaa_pkg::su_ctl_type       ctl,
   input  wire logic [jaa_pkg::NUM_W-1:0] num,
   input  wire logic [jaa_pkg::DEN_W-1:0] den,
   output      jaa_pkg::su_sts_type       sts,
   output      logic [jaa_pkg::Q_W-1:0]   result
);
   import jaa_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   su_mode_type       mode_ff, mode_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [SQ_W-1:0]   src_ff, src_in;
   logic [DSH_W-1:0]  dsh_ff, dsh_in;
   logic [Q_W-1:0]    acc_ff, acc_in;

   logic [SQ_REM_W+1:0] sq_rem_t;
   logic [SQ_REM_W+1:0] sq_trial;
   logic                sq_ge;
   logic                dv_ge;

   // one step of either algorithm
   always_comb begin
      sq_rem_t = {rem_ff[SQ_REM_W-1:0], src_ff[SQ_W-1 -: 2]};
      sq_trial = {1'b0, acc_ff[ROOT_W-1:0], 2'b01};
      sq_ge    = (sq_rem_t >= sq_trial);
      dv_ge    = ({(DSH_W-NUM_W)'(0), rem_ff} >= dsh_ff);

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      src_in  = src_ff;
      dsh_in  = dsh_ff;
      acc_in  = acc_ff;

      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         acc_in  = '0;
         if (ctl.mode == SU_SQRT) begin
            rem_in  = '0;
            src_in  = num[SQ_W-1:0];
            step_in = STEP_W'(SQ_STEPS - 1);
         end else begin
            rem_in  = num;
            dsh_in  = {den, (Q_W-1)'(0)};
            step_in = STEP_W'(DIV_STEPS - 1);
         end
      end else if (busy_ff) begin
         if (mode_ff == SU_SQRT) begin
            rem_in = NUM_W'(sq_ge ? (sq_rem_t - sq_trial) : sq_rem_t);
            src_in = {src_ff[SQ_W-3:0], 2'b00};
            acc_in = {acc_ff[Q_W-2:0], sq_ge};
         end else begin
            rem_in = dv_ge ? (rem_ff - dsh_ff[NUM_W-1:0]) : rem_ff;
            dsh_in = {1'b0, dsh_ff[DSH_W-1:1]};
            acc_in = {acc_ff[Q_W-2:0], dv_ge};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      dsh_ff  <= dsh_in;
      acc_ff  <= acc_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = acc_ff;

   // checks
   `JAA_ASSERT_IMP(a_no_restart, clock, reset, ctl.start, !busy_ff, "start while busy")
   `JAA_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff, "done while busy")
   `JAA_ASSERT_NXT(a_start_busy, clock, reset, ctl.start, busy_ff, "start did not go busy")

endmodule

`default_nettype wire

[design/jet_angularity_accumulator_unit.sv]
// ---------------------------------------------------------------------------
// jet_angularity_accumulator_unit
// Accumulates jet constituents and gives four radius-scaled angularities,
// multiplicity and rapidity bin on the last constituent of each jet.
//
//   Port group   Direction  Handshake        Word
//   req_*        in         valid/ready      jaa_pkg::req_type
//   rsp_*        out        valid/ready      jaa_pkg::rsp_type
//   csr_*        in         write enable     jet radius in tenths (4 bits)
//
// A constituent takes 17 square-root steps in the shared shift/subtract
// unit, then four products through the shared multiplier. A last
// constituent with a nonzero momentum sum adds a 17-step root of that
// sum and four 19-step divisions, all in the same shift/subtract unit.
// req_ready is high only while the sequencer is idle.
// Reset is synchronous; it clears the sums and sets the radius to 4.
// A result waiting on rsp_ready holds the sequencer when the next jet's result is ready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "jet_angularity_accumulator_unit_defines.svh"

module jet_angularity_accumulator_unit #(
   parameter int MAX_PARTICLES = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire jaa_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      jaa_pkg::rsp_type rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [3:0]       csr_write_data
);
   import jaa_pkg::*;

   localparam int LG    = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam int P_W   = 16 + LG;
   localparam int S2_W  = 45 + LG;
   localparam int S1_W  = 29 + LG;
   localparam int SH_W  = 25 + LG;
   localparam int D2_W  = 26 + LG;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_ROOT_GO  = 12'b0000_0000_0010,
      S_ROOT_WT  = 12'b0000_0000_0100,
      S_MUL1     = 12'b0000_0000_1000,
      S_MUL2     = 12'b0000_0001_0000,
      S_MUL3     = 12'b0000_0010_0000,
      S_MUL4     = 12'b0000_0100_0000,
      S_FIN      = 12'b0000_1000_0000,
      S_FIN_ROOT = 12'b0001_0000_0000,
      S_DIV_GO   = 12'b0010_0000_0000,
      S_DIV_WT   = 12'b0100_0000_0000,
      S_EMIT     = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic [11:0]        root_ff, root_in;
   logic [ROOT_W-1:0]  rp_ff, rp_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic [S2_W-1:0]    s2_ff, s2_in;
   logic [S1_W-1:0]    s1_ff, s1_in;
   logic [SH_W-1:0]    sh_ff, sh_in;
   logic [D2_W-1:0]    d2_ff, d2_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]         t_ff;
   logic [1:0]         div_idx_ff, div_idx_in;
   logic [16:0]        ang_ff [0:3];
   logic [16:0]        ang_in [0:3];
   logic               degen_ff, degen_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   su_ctl_type         su_ctl;
   su_sts_type         su_sts;
   logic [NUM_W-1:0]   su_num;
   logic [DEN_W-1:0]   su_den;
   logic [Q_W-1:0]     su_res;

   logic               mul_issue;
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] mul_prod;

   logic               req_acc;
   logic               room;
   logic [7:0]         tt;
   logic [DEN_W-1:0]   den_raw;
   logic [16:0]        q_sat;
   logic               rsp_free;

   jaa_shift_sub u_shift_sub (
      .clock  (clock),
      .reset  (reset),
      .ctl    (su_ctl),
      .num    (su_num),
      .den    (su_den),
      .sts    (su_sts),
      .result (su_res)
   );

   jaa_mul u_mul (
      .clock (clock),
      .issue (mul_issue),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign room      = (cnt_ff < CNT_W'(MAX_PARTICLES));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign tt        = 8'(t_ff) * 8'(t_ff);
   assign q_sat     = (su_res > Q_W'(SAT_ONE)) ? SAT_ONE : su_res[16:0];

   // divider operands by angularity index; square-root operand in S_ROOT_GO and S_FIN
   always_comb begin
      case (div_idx_ff)
         2'd0: begin
            su_num  = (NUM_W'(s2_ff) * NUM_W'(t_ff)) << 4;
            den_raw = DEN_W'(mul_prod);
         end
         2'd1: begin
            su_num  = (NUM_W'(s1_ff) * NUM_W'(t_ff)) << 4;
            den_raw = DEN_W'(p_ff);
         end
         2'd2: begin
            su_num  = (NUM_W'(sh_ff) * NUM_W'(t_ff)) << 4;
            den_raw = DEN_W'(rp_ff);
         end
         default: begin
            su_num  = NUM_W'(d2_ff) * NUM_W'(tt);
            den_raw = '0;
         end
      endcase
      if (state_ff == S_ROOT_GO) begin
         su_num = NUM_W'({item_ff.particle_pt, 8'd0});
      end else if (state_ff == S_FIN) begin
         su_num = NUM_W'({p_ff, 8'd0});
      end
      if (div_idx_ff == 2'd3) begin
         su_den = DIST2_DEN;
      end else begin
         su_den = (den_raw << 3) + (den_raw << 1);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      root_in      = root_ff;
      rp_in        = rp_ff;
      p_in         = p_ff;
      s2_in        = s2_ff;
      s1_in        = s1_ff;
      sh_in        = sh_ff;
      d2_in        = d2_ff;
      cnt_in       = cnt_ff;
      div_idx_in   = div_idx_ff;
      ang_in       = ang_ff;
      degen_in     = degen_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      su_ctl.start = 1'b0;
      su_ctl.mode  = SU_SQRT;
      mul_issue    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               item_in = req_data;
               if (room) begin
                  state_in = S_ROOT_GO;
               end else if (req_data.last_particle) begin
                  state_in = S_FIN;
               end
            end
         end
         S_ROOT_GO: begin
            su_ctl.start = 1'b1;
            state_in     = S_ROOT_WT;
         end
         S_ROOT_WT: begin
            if (su_sts.done) begin
               root_in   = su_res[11:0];
               mul_issue = 1'b1;
               mul_a     = MUL_W'(item_ff.particle_pt);
               mul_b     = MUL_W'(item_ff.distance_to_axis);
               state_in  = S_MUL1;
            end
         end
         S_MUL1: begin
            s1_in     = s1_ff + S1_W'(mul_prod);
            mul_issue = 1'b1;
            mul_a     = mul_prod[MUL_W-1:0];
            mul_b     = MUL_W'(item_ff.particle_pt);
            state_in  = S_MUL2;
         end
         S_MUL2: begin
            s2_in     = s2_ff + S2_W'(mul_prod);
            mul_issue = 1'b1;
            mul_a     = MUL_W'(root_ff);
            mul_b     = MUL_W'(item_ff.distance_to_axis);
            state_in  = S_MUL3;
         end
         S_MUL3: begin
            sh_in     = sh_ff + SH_W'(mul_prod);
            mul_issue = 1'b1;
            mul_a     = MUL_W'(item_ff.distance_to_axis);
            mul_b     = MUL_W'(item_ff.distance_to_axis);
            state_in  = S_MUL4;
         end
         S_MUL4: begin
            d2_in    = d2_ff + D2_W'(mul_prod);
            p_in     = p_ff + P_W'(item_ff.particle_pt);
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = item_ff.last_particle ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            div_idx_in = 2'd0;
            if (p_ff == '0) begin
               for (int i = 0; i < 4; i++) ang_in[i] = '0;
               degen_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               degen_in     = 1'b0;
               su_ctl.start = 1'b1;
               mul_issue    = 1'b1;
               mul_a        = MUL_W'(p_ff);
               mul_b        = MUL_W'(p_ff);
               state_in     = S_FIN_ROOT;
            end
         end
         S_FIN_ROOT: begin
            if (su_sts.done) begin
               rp_in    = su_res[ROOT_W-1:0];
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            su_ctl.start = 1'b1;
            su_ctl.mode  = SU_DIV;
            state_in     = S_DIV_WT;
         end
         S_DIV_WT: begin
            if (su_sts.done) begin
               ang_in[div_idx_ff] = q_sat;
               div_idx_in         = div_idx_ff + 2'd1;
               state_in           = (div_idx_ff == 2'd3) ? S_EMIT : S_DIV_GO;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_in.multiplicity       = (32'(cnt_ff) > 32'd511) ? 9'd511 : 9'(cnt_ff);
               rsp_in.angularity_pt2     = ang_ff[0];
               rsp_in.angularity_pt1     = ang_ff[1];
               rsp_in.angularity_pt_half = ang_ff[2];
               rsp_in.angularity_dist2   = ang_ff[3];
               rsp_in.rapidity_valid     = (item_ff.jet_abs_rapidity < RAP_TOP);
               rsp_in.rapidity_bin       = (item_ff.jet_abs_rapidity < RAP_TOP) ?
                                           rap_bin_f(item_ff.jet_abs_rapidity) : 3'd0;
               rsp_in.degenerate         = degen_ff;
               rsp_valid_in              = 1'b1;
               p_in     = '0;
               s2_in    = '0;
               s1_in    = '0;
               sh_in    = '0;
               d2_in    = '0;
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         p_ff         <= '0;
         s2_ff        <= '0;
         s1_ff        <= '0;
         sh_ff        <= '0;
         d2_ff        <= '0;
         cnt_ff       <= '0;
         t_ff         <= 4'd4;
         div_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         s2_ff        <= s2_in;
         s1_ff        <= s1_in;
         sh_ff        <= sh_in;
         d2_ff        <= d2_in;
         cnt_ff       <= cnt_in;
         div_idx_ff   <= div_idx_in;
         if (csr_write_enable) t_ff <= csr_write_data;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      root_ff  <= root_in;
      rp_ff    <= rp_in;
      ang_ff   <= ang_in;
      degen_ff <= degen_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `JAA_ASSERT_IMP(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_PARTICLES), "count over cap")
   `JAA_ASSERT_NXT(a_busy_after_acc, clock, reset, req_acc && room, !req_ready, "ready after take")
   `JAA_ASSERT_IMP(a_done_state, clock, reset, su_sts.done,
      state_ff == S_ROOT_WT || state_ff == S_FIN_ROOT || state_ff == S_DIV_WT, "stray done")
   `JAA_ASSERT_IMP(a_rsp_drop, clock, reset, $fell(rsp_valid_ff), $past(rsp_ready), "word lost")

endmodule

`default_nettype wire
